[hdl/ffha_pkg.sv]
// shared constants and payload types for the first-fit heap allocator
package ffha_pkg;

   // default arena geometry
   localparam int HEAP_BYTES_DEF      = 65536;
   localparam int HEADER_BYTES_DEF    = 32;
   localparam int MIN_SPLIT_BYTES_DEF = 8;

   // allocation grain in bytes and width of a rounded request size
   localparam int GRAIN  = 8;
   localparam int NEED_W = 18;

   // request modes
   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_FREE    = 2'd1;
   localparam logic [1:0] MODE_REALLOC = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [16:0] request_size;
      logic        addr_present;
      logic [15:0] payload_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] result_addr;
      logic        granted;
   } rsp_type;

endpackage

[hdl/first_fit_heap_allocator_core.sv]
// first-fit heap allocator: header walk, split and coalesce under one sequencer
// sequence: a request walks block headers in the address lookup or the first-fit search, and
//   a reallocate that moves its block adds lookup decision, split, release and relink
//   steps
// throughput: one request at a time; the next is taken the cycle after the result is
//   registered, and a stalled result holds the block in its final step
// reset: synchronous, clears the break, last-block pointer, heap flag and handshake state;
//   the header memories are not cleared, only blocks in the list are ever read
module first_fit_heap_allocator_core import ffha_pkg::*; #(
   parameter int HEAP_BYTES      = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
   parameter int MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DEPTH  = HEAP_BYTES / GRAIN;
   localparam int SW     = $clog2(DEPTH);
   localparam int OW_MIN = $clog2(HEAP_BYTES) + 1;
   localparam int OW     = (OW_MIN > NEED_W) ? OW_MIN : NEED_W;
   localparam int HDR    = ((HEADER_BYTES + GRAIN - 1) / GRAIN) * GRAIN;

   typedef logic [OW-1:0] off_type;
   typedef logic [OW:0]   wide_type;
   typedef logic [SW-1:0] slot_type;
   typedef logic [SW:0]   link_type;

   localparam off_type  HDR_W   = OW'(HDR);
   localparam wide_type SPLIT_W = (OW + 1)'(HDR + MIN_SPLIT_BYTES);
   localparam wide_type HEAP_W  = (OW + 1)'(HEAP_BYTES);

   typedef enum logic [21:0] {
      ST_IDLE    = 22'd1,
      ST_F_TEST  = 22'd2,
      ST_F_NEXT  = 22'd4,
      ST_F_GOT   = 22'd8,
      ST_G_RD    = 22'd16,
      ST_G_CHK   = 22'd32,
      ST_G_WR    = 22'd64,
      ST_A_TEST  = 22'd128,
      ST_A_CHK   = 22'd256,
      ST_A_APP   = 22'd512,
      ST_SP0     = 22'd1024,
      ST_SP1     = 22'd2048,
      ST_SP_DONE = 22'd4096,
      ST_RELINK  = 22'd8192,
      ST_R_RD    = 22'd16384,
      ST_R_GOT   = 22'd32768,
      ST_R_N     = 22'd65536,
      ST_R_NCHK  = 22'd131072,
      ST_R_NWR   = 22'd262144,
      ST_R_P     = 22'd524288,
      ST_R_PCHK  = 22'd1048576,
      ST_FIN     = 22'd2097152
   } state_type;

   // header memories, one entry per grain slot
   off_type  size_mem [DEPTH];
   link_type prev_mem [DEPTH];
   logic     free_mem [DEPTH];

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0] op_ff, op_in;
   logic       reqz_ff, reqz_in, relpend_ff, relpend_in, ok_ff, ok_in;
   off_type    need_ff, need_in, tgt_ff, tgt_in, cur_ff, cur_in, csize_ff, csize_in;
   off_type    nxt_ff, nxt_in, old_ff, old_in, lnk_ff, lnk_in, lsize_ff, lsize_in;
   off_type    brk_ff, brk_in;
   link_type   cprev_ff, cprev_in;
   slot_type   last_ff, last_in;
   logic       nonempty_ff, nonempty_in;
   logic [15:0] raddr_ff, raddr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // memory read data
   off_type  rsize_ff;
   link_type rprev_ff;
   logic     rfree_ff;

   // memory port controls
   slot_type ra, wa;
   logic     we_size, we_prev, we_free;
   off_type  wd_size;
   link_type wd_prev;
   logic     wd_free;

   // datapath helpers
   off_type  cur_hdr, split_pos, split_rem, rl_next, grow, psum, p_off, tgt_req;
   wide_type split_min, app_end;
   slot_type p_slot;
   logic [NEED_W-1:0] need_sum;
   logic     find_ok;

   assign cur_hdr   = cur_ff + HDR_W;
   assign split_pos = cur_hdr + need_ff;
   assign split_rem = csize_ff - need_ff - HDR_W;
   assign rl_next   = lnk_ff + HDR_W + lsize_ff;
   assign grow      = csize_ff + HDR_W + rsize_ff;
   assign psum      = rsize_ff + HDR_W + csize_ff;
   assign p_slot    = SW'(cprev_ff - 1'b1);
   assign p_off     = OW'({p_slot, 3'b000});
   assign split_min = (OW + 1)'(need_ff) + SPLIT_W;
   assign app_end   = (OW + 1)'(brk_ff) + (OW + 1)'(HDR) + (OW + 1)'(need_ff);
   assign need_sum  = NEED_W'(req_data.request_size) + NEED_W'(7);
   assign tgt_req   = OW'(req_data.payload_addr) - HDR_W;
   assign find_ok   = nonempty_ff && (OW'(req_data.payload_addr) >= HDR_W);

   // header memories: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we_size) size_mem[wa] <= wd_size;
      if (we_prev) prev_mem[wa] <= wd_prev;
      if (we_free) free_mem[wa] <= wd_free;
      rsize_ff <= size_mem[ra];
      rprev_ff <= prev_mem[ra];
      rfree_ff <= free_mem[ra];
   end

   // read address select
   always_comb begin
      case (state_ff)
         ST_G_RD, ST_R_N: ra = nxt_ff[SW+2:3];
         ST_R_P:          ra = p_slot;
         default:         ra = cur_ff[SW+2:3];
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      op_in       = op_ff;
      reqz_in     = reqz_ff;
      relpend_in  = relpend_ff;
      ok_in       = ok_ff;
      need_in     = need_ff;
      tgt_in      = tgt_ff;
      cur_in      = cur_ff;
      csize_in    = csize_ff;
      cprev_in    = cprev_ff;
      nxt_in      = nxt_ff;
      old_in      = old_ff;
      lnk_in      = lnk_ff;
      lsize_in    = lsize_ff;
      brk_in      = brk_ff;
      last_in     = last_ff;
      nonempty_in = nonempty_ff;
      raddr_in    = raddr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wa      = cur_ff[SW+2:3];
      we_size = 1'b0;
      we_prev = 1'b0;
      we_free = 1'b0;
      wd_size = need_ff;
      wd_prev = '0;
      wd_free = 1'b0;

      case (state_ff)
         // take a request and pick the path
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.mode;
               reqz_in    = (req_data.request_size == '0);
               need_in    = OW'({need_sum[NEED_W-1:3], 3'b000});
               tgt_in     = tgt_req;
               cur_in     = '0;
               relpend_in = 1'b0;
               ok_in      = 1'b0;
               raddr_in   = '0;
               state_in   = ST_FIN;
               case (req_data.mode)
                  MODE_ALLOC: begin
                     if (req_data.request_size != '0) state_in = ST_A_TEST;
                  end
                  MODE_FREE: begin
                     if (req_data.addr_present && find_ok) state_in = ST_F_TEST;
                  end
                  MODE_REALLOC: begin
                     if (!req_data.addr_present) begin
                        if (req_data.request_size != '0) state_in = ST_A_TEST;
                     end else if (find_ok) begin
                        state_in = ST_F_TEST;
                     end
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end

         // address lookup walk
         ST_F_TEST: begin
            if (cur_ff < brk_ff && cur_ff <= tgt_ff) begin
               state_in = (cur_ff == tgt_ff) ? ST_F_GOT : ST_F_NEXT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_F_NEXT: begin
            cur_in   = cur_hdr + rsize_ff;
            state_in = ST_F_TEST;
         end
         ST_F_GOT: begin
            csize_in = rsize_ff;
            nxt_in   = cur_hdr + rsize_ff;
            old_in   = cur_ff;
            if (rfree_ff) begin
               state_in = ST_FIN;
            end else if (op_ff == MODE_FREE || reqz_ff) begin
               state_in = ST_R_RD;
            end else if (rsize_ff >= need_ff) begin
               ok_in    = 1'b1;
               raddr_in = 16'(cur_hdr);
               state_in = ST_SP0;
            end else if (cur_hdr + rsize_ff < brk_ff) begin
               state_in = ST_G_RD;
            end else begin
               relpend_in = 1'b1;
               cur_in     = '0;
               state_in   = ST_A_TEST;
            end
         end

         // grow into a free next block
         ST_G_RD: state_in = ST_G_CHK;
         ST_G_CHK: begin
            if (rfree_ff && grow >= need_ff) begin
               csize_in = grow;
               lnk_in   = cur_ff;
               lsize_in = grow;
               state_in = ST_G_WR;
            end else begin
               relpend_in = 1'b1;
               cur_in     = '0;
               state_in   = ST_A_TEST;
            end
         end
         ST_G_WR: begin
            we_size  = 1'b1;
            wd_size  = csize_ff;
            ok_in    = 1'b1;
            raddr_in = 16'(cur_hdr);
            ret_in   = ST_SP0;
            state_in = ST_RELINK;
         end

         // first-fit search
         ST_A_TEST: begin
            state_in = (nonempty_ff && cur_ff < brk_ff) ? ST_A_CHK : ST_A_APP;
         end
         ST_A_CHK: begin
            if (rfree_ff && rsize_ff >= need_ff) begin
               we_free  = 1'b1;
               wd_free  = 1'b0;
               csize_in = rsize_ff;
               ok_in    = 1'b1;
               raddr_in = 16'(cur_hdr);
               state_in = ST_SP0;
            end else begin
               cur_in   = cur_hdr + rsize_ff;
               state_in = ST_A_TEST;
            end
         end

         // append at the break
         ST_A_APP: begin
            if (app_end > HEAP_W) begin
               state_in = ST_FIN;
            end else begin
               wa          = brk_ff[SW+2:3];
               we_size     = 1'b1;
               we_prev     = 1'b1;
               we_free     = 1'b1;
               wd_size     = need_ff;
               wd_free     = 1'b0;
               wd_prev     = nonempty_ff ? (link_type'(last_ff) + 1'b1) : '0;
               last_in     = brk_ff[SW+2:3];
               brk_in      = OW'(app_end);
               nonempty_in = 1'b1;
               ok_in       = 1'b1;
               raddr_in    = 16'(brk_ff + HDR_W);
               if (relpend_ff) begin
                  cur_in   = old_ff;
                  state_in = ST_R_RD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end

         // split off the tail of the current block when the remainder is large enough
         ST_SP0: begin
            if ((OW + 1)'(csize_ff) >= split_min) begin
               wa       = split_pos[SW+2:3];
               we_size  = 1'b1;
               we_prev  = 1'b1;
               we_free  = 1'b1;
               wd_size  = split_rem;
               wd_free  = 1'b1;
               wd_prev  = link_type'(cur_ff[SW+2:3]) + 1'b1;
               lnk_in   = split_pos;
               lsize_in = split_rem;
               state_in = ST_SP1;
            end else begin
               state_in = ST_SP_DONE;
            end
         end
         ST_SP1: begin
            we_size  = 1'b1;
            wd_size  = need_ff;
            ret_in   = ST_SP_DONE;
            state_in = ST_RELINK;
         end
         ST_SP_DONE: begin
            if (relpend_ff) begin
               cur_in   = old_ff;
               state_in = ST_R_RD;
            end else begin
               state_in = ST_FIN;
            end
         end

         // point the block after lnk back at it, or move the last marker
         ST_RELINK: begin
            if (rl_next < brk_ff) begin
               wa      = rl_next[SW+2:3];
               we_prev = 1'b1;
               wd_prev = link_type'(lnk_ff[SW+2:3]) + 1'b1;
            end else begin
               last_in = lnk_ff[SW+2:3];
            end
            state_in = ret_ff;
         end

         // release with merge into free neighbors
         ST_R_RD: state_in = ST_R_GOT;
         ST_R_GOT: begin
            we_free  = 1'b1;
            wd_free  = 1'b1;
            csize_in = rsize_ff;
            cprev_in = rprev_ff;
            nxt_in   = cur_hdr + rsize_ff;
            state_in = ST_R_N;
         end
         ST_R_N: begin
            state_in = (nxt_ff < brk_ff) ? ST_R_NCHK : ST_R_P;
         end
         ST_R_NCHK: begin
            if (rfree_ff) begin
               csize_in = grow;
               lnk_in   = cur_ff;
               lsize_in = grow;
               state_in = ST_R_NWR;
            end else begin
               state_in = ST_R_P;
            end
         end
         ST_R_NWR: begin
            we_size  = 1'b1;
            wd_size  = csize_ff;
            ret_in   = ST_R_P;
            state_in = ST_RELINK;
         end
         ST_R_P: begin
            state_in = (cprev_ff != '0) ? ST_R_PCHK : ST_FIN;
         end
         ST_R_PCHK: begin
            if (rfree_ff) begin
               wa       = p_slot;
               we_size  = 1'b1;
               wd_size  = psum;
               lnk_in   = p_off;
               lsize_in = psum;
               ret_in   = ST_FIN;
               state_in = ST_RELINK;
            end else begin
               state_in = ST_FIN;
            end
         end

         // hand the result to the output register
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.granted     = ok_ff;
               rsp_data_in.result_addr = ok_ff ? raddr_ff : 16'd0;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_FIN;
         brk_ff       <= '0;
         last_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         relpend_ff   <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         brk_ff       <= brk_in;
         last_ff      <= last_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
         relpend_ff   <= relpend_in;
         ok_ff        <= ok_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      reqz_ff     <= reqz_in;
      need_ff     <= need_in;
      tgt_ff      <= tgt_in;
      cur_ff      <= cur_in;
      csize_ff    <= csize_in;
      cprev_ff    <= cprev_in;
      nxt_ff      <= nxt_in;
      old_ff      <= old_in;
      lnk_ff      <= lnk_in;
      lsize_ff    <= lsize_in;
      raddr_ff    <= raddr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the break never runs past the arena
   a_brk_bound: assert property (@(posedge clock) disable iff (reset)
      (OW + 1)'(brk_ff) <= HEAP_W)
      else $error("break beyond arena");

   // an empty heap has its break at zero
   a_empty_brk: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> (brk_ff == '0))
      else $error("empty heap with nonzero break");

   // a taken request keeps the block busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a grant always carries a payload address past the first header
   a_grant_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted) |-> (OW'(rsp_data.result_addr) >= HDR_W))
      else $error("granted address inside first header");

endmodule
